@@ sv/point_projection_z_buffer_defines.svh @@
// Assertion macros for the point projection z-buffer.
// Used by the controller; expects clk and rst_n in scope.
`ifndef POINT_PROJECTION_Z_BUFFER_DEFINES_SVH
`define POINT_PROJECTION_Z_BUFFER_DEFINES_SVH

// Same-cycle implication.
`define PPZB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPZB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ppzb_pkg.sv @@
// Shared types, constants and the MAC step table of the point projection z-buffer.
// No dependencies.
package ppzb_pkg;

  localparam int IMG_WIDTH_DEF  = 640;
  localparam int IMG_HEIGHT_DEF = 480;

  localparam int CAM_W  = 34;
  localparam int ACC_W  = 56;
  localparam int REM_W  = 50;
  localparam int Q_W    = 10;
  localparam int STEP_W = 5;
  localparam int PADDR_W = 6;

  localparam logic [STEP_W-1:0] CZ_CHECK   = 5'd9;
  localparam logic [STEP_W-1:0] MAC_LAST   = 5'd16;
  localparam logic [STEP_W-1:0] DIV_FIRST  = 5'd0;
  localparam logic [STEP_W-1:0] DIV_X_DONE = 5'd11;
  localparam logic [STEP_W-1:0] DIV_LAST   = 5'd21;

  localparam logic [23:0] DEPTH_EMPTY = 24'hFFFFFF;
  localparam logic [23:0] DEPTH_MAX   = 24'hFFFFFE;

  localparam logic [2:0] REG_ROW_X    = 3'd0;
  localparam logic [2:0] REG_ROW_Y    = 3'd1;
  localparam logic [2:0] REG_ROW_Z    = 3'd2;
  localparam logic [2:0] REG_FOCAL_X  = 3'd3;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd4;
  localparam logic [2:0] REG_CENTER_X = 3'd5;
  localparam logic [2:0] REG_CENTER_Y = 3'd6;

  localparam logic [63:0] ROW_X_RST    = 64'd8192;
  localparam logic [63:0] ROW_Y_RST    = 64'd536870912;
  localparam logic [63:0] ROW_Z_RST    = 64'd35184372088832;
  localparam logic [15:0] FOCAL_X_RST  = 16'd24964;
  localparam logic [15:0] FOCAL_Y_RST  = 16'd24946;
  localparam logic [15:0] CENTER_X_RST = 16'd20512;
  localparam logic [15:0] CENTER_Y_RST = 16'd15365;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {
    DST_NONE, DST_CX, DST_CY, DST_CZ, DST_NX, DST_NY
  } dst_t;

  typedef struct packed {
    logic       proj;
    logic [1:0] row;
    logic [1:0] col;
    logic       axis;
    logic       ctr;
    logic       hi;
    logic       first;
    dst_t       dst;
  } mac_sel_t;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic              load_in;
    logic              mac_en;
    logic [STEP_W-1:0] step;
    logic              div_init;
    logic              div_axis;
    logic              div_step;
    logic              px_store;
    logic              addr_en;
    logic              mem_rd;
    logic              upd_en;
    logic              out_load;
    logic              clr_en;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic cz_pos;
    logic num_bad;
    logic in_img;
    logic clr_last;
  } sts_t;

  function automatic mac_sel_t mk_row(input logic [1:0] row, input logic [1:0] col,
                                      input dst_t dst);
    mac_sel_t s;
    s.proj  = 1'b0;
    s.row   = row;
    s.col   = col;
    s.axis  = 1'b0;
    s.ctr   = 1'b0;
    s.hi    = 1'b0;
    s.first = (col == AX_X);
    s.dst   = dst;
    return s;
  endfunction

  function automatic mac_sel_t mk_proj(input logic axis, input logic ctr, input logic hi,
                                       input dst_t dst);
    mac_sel_t s;
    s.proj  = 1'b1;
    s.row   = AX_X;
    s.col   = AX_X;
    s.axis  = axis;
    s.ctr   = ctr;
    s.hi    = hi;
    s.first = !ctr && !hi;
    s.dst   = dst;
    return s;
  endfunction

  // Projection step table: three rows of the transform, then f*c + ctr*z per axis
  function automatic mac_sel_t mac_sel(input logic [STEP_W-1:0] step);
    mac_sel_t s;
    unique case (step)
      5'd0:    s = mk_row(AX_X, AX_X, DST_NONE);
      5'd1:    s = mk_row(AX_X, AX_Y, DST_NONE);
      5'd2:    s = mk_row(AX_X, AX_Z, DST_CX);
      5'd3:    s = mk_row(AX_Y, AX_X, DST_NONE);
      5'd4:    s = mk_row(AX_Y, AX_Y, DST_NONE);
      5'd5:    s = mk_row(AX_Y, AX_Z, DST_CY);
      5'd6:    s = mk_row(AX_Z, AX_X, DST_NONE);
      5'd7:    s = mk_row(AX_Z, AX_Y, DST_NONE);
      5'd8:    s = mk_row(AX_Z, AX_Z, DST_CZ);
      5'd9:    s = mk_proj(1'b0, 1'b0, 1'b0, DST_NONE);
      5'd10:   s = mk_proj(1'b0, 1'b0, 1'b1, DST_NONE);
      5'd11:   s = mk_proj(1'b0, 1'b1, 1'b0, DST_NONE);
      5'd12:   s = mk_proj(1'b0, 1'b1, 1'b1, DST_NX);
      5'd13:   s = mk_proj(1'b1, 1'b0, 1'b0, DST_NONE);
      5'd14:   s = mk_proj(1'b1, 1'b0, 1'b1, DST_NONE);
      5'd15:   s = mk_proj(1'b1, 1'b1, 1'b0, DST_NONE);
      5'd16:   s = mk_proj(1'b1, 1'b1, 1'b1, DST_NY);
      default: s = mk_proj(1'b1, 1'b1, 1'b1, DST_NONE);
    endcase
    return s;
  endfunction

endpackage

@@ sv/point_projection_z_buffer.sv @@
// Projection request: transform on the shared MAC, two divisions, then the memory update; it is
// dropped at depth <= 0 after the transform rows, or on quotient overflow before division.
// Read request: address, memory read and update, then the registered result (outside the image
// straight after addressing); one request in flight (shared MAC, bit-serial divider, memory port).
// Reset: a clearing pass over all IMG_WIDTH*IMG_HEIGHT pixels (307200 by default) empties every
// pixel; in_stall stays high meanwhile, configuration writes are taken throughout.
module point_projection_z_buffer #(
  parameter int IMG_WIDTH  = ppzb_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = ppzb_pkg::IMG_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic signed [15:0]           in_pos_x,
  input  logic signed [15:0]           in_pos_y,
  input  logic signed [15:0]           in_pos_z,
  input  logic [7:0]                   in_red_in,
  input  logic [7:0]                   in_green_in,
  input  logic [7:0]                   in_blue_in,
  input  logic [9:0]                   in_read_col,
  input  logic [9:0]                   in_read_row,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_depth_out,
  output logic [7:0]                   out_red_out,
  output logic [7:0]                   out_green_out,
  output logic [7:0]                   out_blue_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppzb_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import ppzb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  ppzb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ppzb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppzb_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_read_col   (in_read_col),
    .in_read_row   (in_read_row),
    .out_depth_out (out_depth_out),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

endmodule

@@ sv/ppzb_regs.sv @@
// Configuration register file with APB-style access.
// Depends on ppzb_pkg.
module ppzb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppzb_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output ppzb_pkg::cfg_t              cfg
);
  import ppzb_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr[5:3];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_x    <= ROW_X_RST;
      cfg_r.row_y    <= ROW_Y_RST;
      cfg_r.row_z    <= ROW_Z_RST;
      cfg_r.focal_x  <= FOCAL_X_RST;
      cfg_r.focal_y  <= FOCAL_Y_RST;
      cfg_r.center_x <= CENTER_X_RST;
      cfg_r.center_y <= CENTER_Y_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_X:    cfg_r.row_x    <= pwdata;
        REG_ROW_Y:    cfg_r.row_y    <= pwdata;
        REG_ROW_Z:    cfg_r.row_z    <= pwdata;
        REG_FOCAL_X:  cfg_r.focal_x  <= pwdata[15:0];
        REG_FOCAL_Y:  cfg_r.focal_y  <= pwdata[15:0];
        REG_CENTER_X: cfg_r.center_x <= pwdata[15:0];
        REG_CENTER_Y: cfg_r.center_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_X:    prdata = cfg_r.row_x;
      REG_ROW_Y:    prdata = cfg_r.row_y;
      REG_ROW_Z:    prdata = cfg_r.row_z;
      REG_FOCAL_X:  prdata = {48'd0, cfg_r.focal_x};
      REG_FOCAL_Y:  prdata = {48'd0, cfg_r.focal_y};
      REG_CENTER_X: prdata = {48'd0, cfg_r.center_x};
      REG_CENTER_Y: prdata = {48'd0, cfg_r.center_y};
      default:      prdata = '0;
    endcase
  end

endmodule

@@ sv/ppzb_dp.sv @@
// Datapath: shared MAC, restoring divider, pixel addressing and the depth/colour memory.
// Depends on ppzb_pkg; driven by ppzb_ctrl commands.
module ppzb_dp #(
  parameter int IMG_WIDTH  = ppzb_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = ppzb_pkg::IMG_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppzb_pkg::cfg_t     cfg,
  input  ppzb_pkg::cmd_t     cmd,
  output ppzb_pkg::sts_t     sts,
  input  logic               in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic [9:0]         in_read_col,
  input  logic [9:0]         in_read_row,
  output logic [15:0]        out_depth_out,
  output logic [7:0]         out_red_out,
  output logic [7:0]         out_green_out,
  output logic [7:0]         out_blue_out
);
  import ppzb_pkg::*;

  localparam int PIX    = IMG_WIDTH * IMG_HEIGHT;
  localparam int ADDR_W = (PIX > 1) ? $clog2(PIX) : 1;

  logic               kind_r;
  logic signed [15:0] pos_x_r, pos_y_r, pos_z_r;
  logic [23:0]        color_r;
  logic [9:0]         rcol_r, rrow_r;

  logic signed [ACC_W-1:0] acc_r, acc_nxt, base, prod_ext, lim;
  logic signed [CAM_W-1:0] cx_r, cy_r, cz_r, src;
  logic signed [ACC_W-1:0] nx_r, ny_r;
  logic signed [17:0]      op_a, op_b;
  logic signed [35:0]      prod;
  logic signed [15:0]      coef, pos, off;
  logic [15:0]             fc;
  logic [63:0]             row_w;
  mac_sel_t                sel;

  logic [REM_W-1:0] rem_r, dsh_r;
  logic [Q_W-1:0]   q_r, px_r;
  logic             ge;

  logic [9:0]        col_sel, row_sel;
  logic [20:0]       idx_full;
  logic [ADDR_W-1:0] addr_r, clr_cnt_r, mem_wa;
  logic              zero_r;
  logic [23:0]       dq;

  logic [47:0] mem [PIX];
  logic [47:0] rd_q, mem_wd;
  logic        mem_we;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      color_r <= {in_red_in, in_green_in, in_blue_in};
      rcol_r  <= in_read_col;
      rrow_r  <= in_read_row;
    end
  end

  always_comb begin
    sel = mac_sel(cmd.step);
    unique case (sel.row)
      AX_X:    row_w = cfg.row_x;
      AX_Y:    row_w = cfg.row_y;
      default: row_w = cfg.row_z;
    endcase
    unique case (sel.col)
      AX_X: begin
        coef = row_w[15:0];
        pos  = pos_x_r;
      end
      AX_Y: begin
        coef = row_w[31:16];
        pos  = pos_y_r;
      end
      default: begin
        coef = row_w[47:32];
        pos  = pos_z_r;
      end
    endcase
    off = row_w[63:48];
    if (sel.ctr) begin
      src = cz_r;
    end else if (sel.axis) begin
      src = cy_r;
    end else begin
      src = cx_r;
    end
    if (sel.axis) begin
      fc = sel.ctr ? cfg.center_y : cfg.focal_y;
    end else begin
      fc = sel.ctr ? cfg.center_x : cfg.focal_x;
    end
    if (sel.proj) begin
      op_a = {2'b00, fc};
      op_b = sel.hi ? {src[CAM_W-1], src[CAM_W-1:17]} : {1'b0, src[16:0]};
      base = '0;
    end else begin
      op_a = {{2{coef[15]}}, coef};
      op_b = {{2{pos[15]}}, pos};
      base = {{(ACC_W-29){off[15]}}, off, 13'd0};
    end
    prod     = op_a * op_b;
    prod_ext = sel.hi ? {{(ACC_W-53){prod[35]}}, prod, 17'd0}
                      : {{(ACC_W-36){prod[35]}}, prod};
    acc_nxt  = (sel.first ? base : acc_r) + prod_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_r <= acc_nxt;
      unique case (sel.dst)
        DST_CX:  cx_r <= acc_nxt[CAM_W-1:0];
        DST_CY:  cy_r <= acc_nxt[CAM_W-1:0];
        DST_CZ:  cz_r <= acc_nxt[CAM_W-1:0];
        DST_NX:  nx_r <= acc_nxt;
        DST_NY:  ny_r <= acc_nxt;
        default: ;
      endcase
    end
  end

  assign lim = {{(ACC_W-CAM_W-16){1'b0}}, cz_r, 16'd0};
  assign ge  = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= cmd.div_axis ? ny_r[REM_W-1:0] : nx_r[REM_W-1:0];
      dsh_r <= {{(REM_W-CAM_W-14){1'b0}}, cz_r[CAM_W-2:0], 15'd0};
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? (rem_r - dsh_r) : rem_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
    if (cmd.px_store) begin
      px_r <= q_r;
    end
  end

  assign col_sel  = kind_r ? rcol_r : px_r;
  assign row_sel  = kind_r ? rrow_r : q_r;
  assign idx_full = 21'(row_sel) * 21'(IMG_WIDTH) + 21'(col_sel);

  assign dq = (cz_r[CAM_W-1:5] > 29'(DEPTH_MAX)) ? DEPTH_MAX : cz_r[28:5];

  always_comb begin
    sts.kind     = kind_r;
    sts.cz_pos   = !cz_r[CAM_W-1] && (cz_r != '0);
    sts.num_bad  = nx_r[ACC_W-1] || (nx_r >= lim) || ny_r[ACC_W-1] || (ny_r >= lim);
    sts.in_img   = ({1'b0, col_sel} < 11'(IMG_WIDTH)) && ({1'b0, row_sel} < 11'(IMG_HEIGHT));
    sts.clr_last = (clr_cnt_r == ADDR_W'(PIX - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      addr_r <= idx_full[ADDR_W-1:0];
      zero_r <= !sts.in_img;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  assign mem_we = cmd.clr_en || (cmd.upd_en && (kind_r || (dq < rd_q[47:24])));
  assign mem_wa = cmd.clr_en ? clr_cnt_r : addr_r;
  assign mem_wd = (cmd.clr_en || kind_r) ? {DEPTH_EMPTY, 24'd0} : {dq, color_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_depth_out <= (zero_r || rd_q[47:24] == DEPTH_EMPTY) ? 16'd0 : rd_q[47:32];
      out_red_out   <= zero_r ? 8'd0 : rd_q[23:16];
      out_green_out <= zero_r ? 8'd0 : rd_q[15:8];
      out_blue_out  <= zero_r ? 8'd0 : rd_q[7:0];
    end
  end

endmodule

@@ sv/ppzb_ctrl.sv @@
// Controller: sequences clearing, transform, division and the memory update per request.
// Depends on ppzb_pkg and point_projection_z_buffer_defines.svh.
module ppzb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ppzb_pkg::sts_t sts,
  output ppzb_pkg::cmd_t cmd
);
  import ppzb_pkg::*;
  `include "point_projection_z_buffer_defines.svh"

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_XFORM  = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_ADDR   = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.step      = step_r;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_kind ? S_ADDR : S_XFORM;
        end
      end
      S_XFORM: begin
        if (step_r == CZ_CHECK && !sts.cz_pos) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.mac_en = 1'b1;
          if (step_r == MAC_LAST) begin
            state_nxt = S_DIV;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (step_r == DIV_FIRST && sts.num_bad) begin
          state_nxt = S_IDLE;
        end else begin
          if (step_r == DIV_FIRST) begin
            cmd.div_init = 1'b1;
          end else if (step_r == DIV_X_DONE) begin
            cmd.px_store = 1'b1;
            cmd.div_init = 1'b1;
            cmd.div_axis = 1'b1;
          end else begin
            cmd.div_step = 1'b1;
          end
          if (step_r == DIV_LAST) begin
            state_nxt = S_ADDR;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      S_ADDR: begin
        cmd.addr_en = 1'b1;
        if (sts.in_img) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = sts.kind ? S_RESULT : S_IDLE;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd_en = 1'b1;
        state_nxt  = sts.kind ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PPZB_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_r && out_stall), "result overwritten while stalled")
  `PPZB_ASSERT_NXT(a_leave_idle, accept, state_r != S_IDLE, "accepted request left controller idle")
  `PPZB_ASSERT_IMP(a_clear_blocks, state_r == S_CLEAR, in_stall && !cmd.mem_rd, "request taken during clear")
  `PPZB_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_r), "state not one-hot")

endmodule

@@ tb/sv/tb_point_projection_z_buffer.sv @@
// Self-checking testbench for the point projection z-buffer: point and read requests,
// checked against an in-bench z-buffer predictor. Depends on ppzb_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_point_projection_z_buffer;
  import ppzb_pkg::*;

  localparam int PIX_COUNT = IMG_WIDTH_DEF * IMG_HEIGHT_DEF;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS = 225;
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [23:0] NO_DEPTH = 24'hFFFFFF;
  localparam logic [23:0] DEPTH_CAP = 24'hFFFFFE;

  typedef struct {
    logic kind;
    logic signed [15:0] x, y, z;
    logic [7:0] r, g, b;
    logic [9:0] col, row;
  } pix_req_t;

  typedef struct {
    logic [15:0] depth;
    logic [7:0] r, g, b;
  } pix_res_t;

  typedef struct {
    pix_req_t req;
    logic typed;
    pix_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_kind;
  logic signed [15:0] in_pos_x, in_pos_y, in_pos_z;
  logic [7:0] in_red_in, in_green_in, in_blue_in;
  logic [9:0] in_read_col, in_read_row;
  logic out_valid, out_stall;
  logic [15:0] out_depth_out;
  logic [7:0] out_red_out, out_green_out, out_blue_out;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;

  logic [63:0] m_row_x, m_row_y, m_row_z;
  logic [15:0] m_focal_x, m_focal_y, m_center_x, m_center_y;
  logic [23:0] depth_map [PIX_COUNT];
  logic [23:0] colour_map [PIX_COUNT];
  int drawn_pix [$];
  int target_pix [8];
  pix_res_t pixel_q [$];

  int mismatches = 0;
  int points_sent = 0, reads_sent = 0, results_seen = 0, draws = 0, cfg_writes = 0;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  int quiet_cycles = 0;

  point_projection_z_buffer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .in_read_col(in_read_col), .in_read_row(in_read_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_depth_out(out_depth_out),
    .out_red_out(out_red_out), .out_green_out(out_green_out), .out_blue_out(out_blue_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint camera_coord(logic [63:0] r, longint x, longint y, longint z);
    return sx16(r[15:0]) * x + sx16(r[31:16]) * y + sx16(r[47:32]) * z
         + sx16(r[63:48]) * 8192;
  endfunction

  function automatic longint pixel_axis(logic [15:0] f, logic [15:0] c, longint v, longint z);
    longint num;
    num = longint'({48'd0, f}) * v + longint'({48'd0, c}) * z;
    if (num < 0) return -1;
    return num / (z * 64);
  endfunction

  function automatic void draw_point(pix_req_t q);
    longint cx, cy, cz, px, py, dq;
    int idx;
    cx = camera_coord(m_row_x, q.x, q.y, q.z);
    cy = camera_coord(m_row_y, q.x, q.y, q.z);
    cz = camera_coord(m_row_z, q.x, q.y, q.z);
    if (cz <= 0) return;
    px = pixel_axis(m_focal_x, m_center_x, cx, cz);
    py = pixel_axis(m_focal_y, m_center_y, cy, cz);
    if (px < 0 || px >= IMG_WIDTH_DEF || py < 0 || py >= IMG_HEIGHT_DEF) return;
    dq = cz >>> 5;
    if (dq > longint'(DEPTH_CAP)) dq = longint'(DEPTH_CAP);
    idx = int'(py) * IMG_WIDTH_DEF + int'(px);
    if (dq[23:0] < depth_map[idx]) begin
      depth_map[idx] = dq[23:0];
      colour_map[idx] = {q.r, q.g, q.b};
      drawn_pix.push_back(idx);
      draws++;
    end
  endfunction

  function automatic pix_res_t read_pixel(pix_req_t q);
    pix_res_t res;
    int idx;
    res = '{16'd0, 8'd0, 8'd0, 8'd0};
    if (q.col >= IMG_WIDTH_DEF || q.row >= IMG_HEIGHT_DEF) return res;
    idx = int'(q.row) * IMG_WIDTH_DEF + int'(q.col);
    res.depth = (depth_map[idx] == NO_DEPTH) ? 16'd0 : depth_map[idx][23:8];
    {res.r, res.g, res.b} = colour_map[idx];
    depth_map[idx] = NO_DEPTH;
    colour_map[idx] = 24'd0;
    return res;
  endfunction

  function automatic logic [15:0] s16(int lo, int hi);
    return 16'($urandom_range(hi - lo) + lo);
  endfunction

  function automatic logic [15:0] fit16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic pix_req_t random_req();
    pix_req_t q;
    int u, v, z, idx;
    q.kind = KIND_POINT;
    q.x = 16'($urandom);
    q.y = 16'($urandom);
    q.z = 16'($urandom);
    q.r = 8'($urandom);
    q.g = 8'($urandom);
    q.b = 8'($urandom);
    q.col = 10'($urandom);
    q.row = 10'($urandom);
    if ($urandom_range(99) < 40) begin
      q.kind = KIND_READ;
      if (drawn_pix.size() != 0 && $urandom_range(99) < 70) begin
        idx = drawn_pix[$urandom_range(drawn_pix.size() - 1)];
        q.col = 10'(idx % IMG_WIDTH_DEF);
        q.row = 10'(idx / IMG_WIDTH_DEF);
      end else if ($urandom_range(99) < 70) begin
        q.col = 10'($urandom_range(IMG_WIDTH_DEF - 1));
        q.row = 10'($urandom_range(IMG_HEIGHT_DEF - 1));
      end
    end else if ($urandom_range(99) < 88) begin
      z = $urandom_range(1, 3000);
      if ($urandom_range(99) < 40) begin
        idx = target_pix[$urandom_range(7)];
        u = idx % IMG_WIDTH_DEF;
        v = idx / IMG_WIDTH_DEF;
      end else begin
        u = $urandom_range(IMG_WIDTH_DEF + 60) - 30;
        v = $urandom_range(IMG_HEIGHT_DEF + 60) - 30;
      end
      q.z = 16'(z);
      q.x = fit16(longint'(u - 320) * z / 390);
      q.y = fit16(longint'(v - 240) * z / 390);
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 3'b000});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROW_X: m_row_x = val;
      REG_ROW_Y: m_row_y = val;
      REG_ROW_Z: m_row_z = val;
      REG_FOCAL_X: m_focal_x = val[15:0];
      REG_FOCAL_Y: m_focal_y = val[15:0];
      REG_CENTER_X: m_center_x = val[15:0];
      REG_CENTER_Y: m_center_y = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic cfg_all(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                         logic [15:0] fx, logic [15:0] fy, logic [15:0] cx, logic [15:0] cy);
    cfg_write(REG_ROW_X, rx);
    cfg_write(REG_ROW_Y, ry);
    cfg_write(REG_ROW_Z, rz);
    cfg_write(REG_FOCAL_X, {48'd0, fx});
    cfg_write(REG_FOCAL_Y, {48'd0, fy});
    cfg_write(REG_CENTER_X, {48'd0, cx});
    cfg_write(REG_CENTER_Y, {48'd0, cy});
  endtask

  task automatic send_req(pix_req_t q, logic typed, pix_res_t want);
    pix_res_t res;
    in_valid <= 1'b1;
    in_kind <= q.kind;
    in_pos_x <= q.x;
    in_pos_y <= q.y;
    in_pos_z <= q.z;
    in_red_in <= q.r;
    in_green_in <= q.g;
    in_blue_in <= q.b;
    in_read_col <= q.col;
    in_read_row <= q.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (q.kind == KIND_READ) begin
      res = read_pixel(q);
      pixel_q.push_back(typed ? want : res);
      reads_sent++;
    end else begin
      draw_point(q);
      points_sent++;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic phase_config(int ph);
    case (ph)
      1, 5: cfg_all({s16(-40, 40), s16(-300, 300), s16(-300, 300), s16(7900, 8500)},
                    {s16(-40, 40), s16(-300, 300), s16(7900, 8500), s16(-300, 300)},
                    {s16(0, 20), s16(7900, 8500), s16(-300, 300), s16(-300, 300)},
                    16'($urandom_range(20000, 30000)), 16'($urandom_range(20000, 30000)),
                    16'($urandom_range(15000, 25000)), 16'($urandom_range(10000, 20000)));
      2: cfg_all(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      3: cfg_all(64'd0, 64'd0, {4{16'h7FFF}}, FOCAL_X_RST, FOCAL_Y_RST,
                 CENTER_X_RST, CENTER_Y_RST);
      4: cfg_all(64'd0, 64'd0, 64'h0000_0001_0000_0000, FOCAL_X_RST, FOCAL_Y_RST,
                 CENTER_X_RST, CENTER_Y_RST);
      6: cfg_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: cfg_all(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, FOCAL_X_RST, FOCAL_Y_RST,
                       CENTER_X_RST, CENTER_Y_RST);
    endcase
    if (ph == 1) cfg_write(REG_UNUSED, {$urandom, $urandom});
  endtask

  // receiver: random stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    pix_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected result, depth", out_depth_out, 0);
      end else begin
        want = pixel_q.pop_front();
        if (out_depth_out !== want.depth) report_mismatch("depth", out_depth_out, want.depth);
        if (out_red_out !== want.r) report_mismatch("red", out_red_out, want.r);
        if (out_green_out !== want.g) report_mismatch("green", out_green_out, want.g);
        if (out_blue_out !== want.b) report_mismatch("blue", out_blue_out, want.b);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_point_projection_z_buffer: done, errors");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [19];
    pix_res_t none;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_POINT;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    in_read_col = '0;
    in_read_row = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    none = '{16'd0, 8'd0, 8'd0, 8'd0};
    m_row_x = ROW_X_RST;
    m_row_y = ROW_Y_RST;
    m_row_z = ROW_Z_RST;
    m_focal_x = FOCAL_X_RST;
    m_focal_y = FOCAL_Y_RST;
    m_center_x = CENTER_X_RST;
    m_center_y = CENTER_Y_RST;
    foreach (depth_map[i]) begin
      depth_map[i] = NO_DEPTH;
      colour_map[i] = 24'd0;
    end
    foreach (target_pix[i]) target_pix[i] = $urandom_range(PIX_COUNT - 1);

    dir_tab[0] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd0, 10'd0}, 1'b1, none};
    dir_tab[1] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd640, 10'd0}, 1'b1, none};
    dir_tab[2] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd1023, 10'd1023}, 1'b1, none};
    dir_tab[3] = '{'{KIND_POINT, 0, 0, 1, 255, 0, 128, 0, 0}, 1'b0, none};
    dir_tab[4] = '{'{KIND_POINT, 0, 0, 5, 1, 2, 3, 0, 0}, 1'b0, none};
    dir_tab[5] = '{'{KIND_POINT, 0, 0, 1, 9, 9, 9, 0, 0}, 1'b0, none};
    dir_tab[6] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd320, 10'd240}, 1'b1,
                   '{16'd1, 8'd255, 8'd0, 8'd128}};
    dir_tab[7] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd320, 10'd240}, 1'b1, none};
    dir_tab[8] = '{'{KIND_POINT, 0, 0, -3, 7, 7, 7, 0, 0}, 1'b0, none};
    dir_tab[9] = '{'{KIND_POINT, 0, 0, 0, 7, 7, 7, 0, 0}, 1'b0, none};
    dir_tab[10] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd320, 10'd240}, 1'b1, none};
    dir_tab[11] = '{'{KIND_POINT, -32768, 0, 1, 255, 255, 255, 0, 0}, 1'b0, none};
    dir_tab[12] = '{'{KIND_POINT, 32767, 32767, 32767, 255, 255, 255, 10'd1023, 10'd1023},
                    1'b0, none};
    dir_tab[13] = '{'{KIND_POINT, -32768, -32768, 32767, 0, 255, 0, 0, 0}, 1'b0, none};
    dir_tab[14] = '{'{KIND_POINT, 0, -1, 2, 170, 85, 255, 0, 0}, 1'b0, none};
    dir_tab[15] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd320, 10'd45}, 1'b1,
                    '{16'd2, 8'd170, 8'd85, 8'd255}};
    dir_tab[16] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd639, 10'd479}, 1'b1, none};
    dir_tab[17] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd0, 10'd1023}, 1'b1, none};
    dir_tab[18] = '{'{KIND_READ, 0, 0, 0, 0, 0, 0, 10'd320, 10'd240}, 1'b0, none};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      phase_config(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 85; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 85; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 60) long_hold_req = 1'b1;
        if (n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (pixel_q.size() != 0) @(posedge clk);
        end
        send_req(random_req(), 1'b0, none);
      end
    end

    drain();
    $display("covered %0d point and %0d read requests over 8 register settings, %0d config writes",
             points_sent, reads_sent, cfg_writes);
    $display("pixels drawn %0d, results checked %0d, mismatches %0d",
             draws, results_seen, mismatches);
    if (mismatches == 0)
      $display("tb_point_projection_z_buffer: done, clean");
    else
      $display("tb_point_projection_z_buffer: done, errors");
    $finish;
  end

endmodule
